FILE: rtl/core/life_grid_generation_step_core_defines.svh
// Assertion helpers for the core module.
`ifndef LIFE_GRID_GENERATION_STEP_CORE_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP_START,
        ST_STEP_WAIT,
        ST_EMIT
    } lgs_state_t;

    typedef logic [1:0] lgs_mode_t;

    localparam lgs_mode_t MODE_LOAD   = 2'd0;
    localparam lgs_mode_t MODE_STEP   = 2'd1;
    localparam lgs_mode_t MODE_EMIT   = 2'd2;
    localparam lgs_mode_t MODE_IGNORE = 2'd3;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic load;
        logic rotate;
    } lgs_ring_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lgs_eng_stat_t;

endpackage

FILE: rtl/core/lgs_grid_ring.sv
`timescale 1ns / 1ps

module lgs_grid_ring #(
    parameter int ROWS = 7,
    parameter int COLS = 20,
    localparam int RW = $clog2(ROWS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lgs_pkg::lgs_ring_ctrl_t ctrl,
    input  logic [RW-1:0]         load_idx,
    input  logic [COLS-1:0]       load_bits,
    input  logic [COLS-1:0]       rot_in,
    output logic [COLS-1:0]       head,
    output logic [COLS-1:0]       second,
    output logic [COLS-1:0]       tail
);
    import lgs_pkg::*;

    logic [COLS-1:0] grid_reg [ROWS];

    // Rotation moves every row one place toward the head; a full pass of
    // ROWS rotations brings the ring back to row order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                grid_reg[i] <= '0;
            end
        end else if (ctrl.rotate) begin
            for (int i = 0; i < ROWS - 1; i++) begin
                grid_reg[i] <= grid_reg[i+1];
            end
            grid_reg[ROWS-1] <= rot_in;
        end else if (ctrl.load) begin
            grid_reg[load_idx] <= load_bits;
        end
    end

    assign head   = grid_reg[0];
    assign second = grid_reg[1];
    assign tail   = grid_reg[ROWS-1];

endmodule

FILE: rtl/core/lgs_row_engine.sv
`timescale 1ns / 1ps

module lgs_row_engine #(
    parameter int COLS = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [COLS-1:0]      up_row,
    input  logic [COLS-1:0]      cur_row,
    input  logic [COLS-1:0]      dn_row,
    output lgs_pkg::lgs_eng_stat_t stat,
    output logic [COLS-1:0]      new_row
);
    import lgs_pkg::*;

    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [COLS-1:0] up_reg, cur_reg, dn_reg, res_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;
    logic [3:0]      nbr;
    logic            alive;

    // Column c sits at bit 0; its wrapped left neighbor is the top bit.
    assign nbr = 4'(up_reg[COLS-1]) + 4'(up_reg[0]) + 4'(up_reg[1])
               + 4'(cur_reg[COLS-1]) + 4'(cur_reg[1])
               + 4'(dn_reg[COLS-1]) + 4'(dn_reg[0]) + 4'(dn_reg[1]);
    assign alive = (nbr == BIRTH_COUNT) || (cur_reg[0] && (nbr == SURVIVE_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(COLS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotate the window one column per cycle; shift each new cell in at the top.
    always_ff @(posedge aclk) begin
        if (start) begin
            up_reg  <= up_row;
            cur_reg <= cur_row;
            dn_reg  <= dn_row;
        end else if (busy_reg) begin
            up_reg  <= {up_reg[0], up_reg[COLS-1:1]};
            cur_reg <= {cur_reg[0], cur_reg[COLS-1:1]};
            dn_reg  <= {dn_reg[0], dn_reg[COLS-1:1]};
            res_reg <= {alive, res_reg[COLS-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign new_row   = res_reg;

endmodule

FILE: rtl/core/life_grid_generation_step_core.sv
`timescale 1ns / 1ps

// Toroidal Game of Life grid (B3/S23) of ROWS rows by COLS columns, held in a
// ring of row registers and cleared by reset. Mode 0 loads one row (row
// indices of ROWS and above are dropped), mode 3 is dropped, mode 2 emits
// all rows from row 0 upward, one item per cycle while m_tready is high, with
// tlast on the final row. Mode 1 first advances one generation: a bit-serial
// evaluator walks each row one column per cycle over a three-row window, then
// the rows are emitted as in mode 2. s_tready is high only while no item is in
// progress.
module life_grid_generation_step_core #(
    parameter int ROWS = 7,
    parameter int COLS = 20,
    localparam int RW  = $clog2(ROWS),
    localparam int SDW = ((2 + RW + COLS + 7) / 8) * 8,
    localparam int MDW = ((RW + COLS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [SDW-1:0] s_tdata,   // mode, row_index, row_bits, zero fill
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [MDW-1:0] m_tdata,   // out_row_index, out_row_bits, zero fill
    output logic           m_tlast
);
    import lgs_pkg::*;

    lgs_state_t      state_reg, state_next;
    logic [RW-1:0]   row_cnt_reg, row_cnt_next;
    logic [COLS-1:0] prev_reg, prev_next;
    logic [COLS-1:0] first_reg, first_next;

    lgs_mode_t       in_mode;
    logic [RW-1:0]   in_idx;
    logic [COLS-1:0] in_bits;

    lgs_ring_ctrl_t  ring_ctrl;
    logic [COLS-1:0] rot_in, ring_head, ring_second, ring_tail;
    logic            eng_start;
    lgs_eng_stat_t   eng_stat;
    logic [COLS-1:0] eng_row;
    logic            row_last;

    assign in_mode = s_tdata[1:0];
    assign in_idx  = s_tdata[2 +: RW];
    assign in_bits = s_tdata[2 + RW +: COLS];

    assign row_last = (row_cnt_reg == RW'(ROWS - 1));

    lgs_grid_ring #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ring_ctrl),
        .load_idx (in_idx),
        .load_bits(in_bits),
        .rot_in   (rot_in),
        .head     (ring_head),
        .second   (ring_second),
        .tail     (ring_tail)
    );

    // The bottom row's lower neighbor is the old row 0, saved at step start.
    lgs_row_engine #(
        .COLS(COLS)
    ) u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (eng_start),
        .up_row (prev_reg),
        .cur_row(ring_head),
        .dn_row (row_last ? first_reg : ring_second),
        .stat   (eng_stat),
        .new_row(eng_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg  <= prev_next;
        first_reg <= first_next;
    end

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        ring_ctrl    = '0;
        rot_in       = ring_head;
        eng_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_mode)
                        MODE_LOAD: begin
                            ring_ctrl.load = ({1'b0, in_idx} < (RW + 1)'(ROWS));
                        end
                        MODE_STEP: begin
                            prev_next    = ring_tail;
                            first_next   = ring_head;
                            row_cnt_next = '0;
                            state_next   = ST_STEP_START;
                        end
                        MODE_EMIT: begin
                            row_cnt_next = '0;
                            state_next   = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STEP_START: begin
                eng_start  = 1'b1;
                state_next = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (eng_stat.done) begin
                    // Retire the old row into the up window, push the new one.
                    ring_ctrl.rotate = 1'b1;
                    rot_in           = eng_row;
                    prev_next        = ring_head;
                    if (row_last) begin
                        row_cnt_next = '0;
                        state_next   = ST_EMIT;
                    end else begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                        state_next   = ST_STEP_START;
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    ring_ctrl.rotate = 1'b1;
                    if (row_last) begin
                        row_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = row_last;
    assign m_tdata  = MDW'({ring_head, row_cnt_reg});

    `include "life_grid_generation_step_core_defines.svh"

    `LGS_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken during emit")
    `LGS_ASSERT_NOW(a_engine_in_step, eng_stat.busy, state_reg == ST_STEP_WAIT, "engine busy outside step")
    `LGS_ASSERT_NEXT(a_emit_ends, m_tvalid && m_tready && m_tlast, s_tready, "no return to idle after last row")
    `LGS_ASSERT_NEXT(a_step_to_emit, eng_stat.done && row_last, m_tvalid && (row_cnt_reg == '0), "emit does not start at row zero")

endmodule

FILE: test/life_grid_generation_step_checker.sv
`timescale 1ns / 1ps

module life_grid_generation_step_checker
    import lgs_pkg::*;
#(
    parameter int ROWS = 7,
    parameter int COLS = 20,
    localparam int RW  = $clog2(ROWS),
    localparam int SDW = ((2 + RW + COLS + 7) / 8) * 8,
    localparam int MDW = ((RW + COLS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [SDW-1:0] s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [MDW-1:0] m_tdata,
    input  logic           m_tlast,
    output int             fail_count,
    output int             rows_pending
);

    typedef struct packed {
        logic [RW-1:0]   row;
        logic [COLS-1:0] cells;
        logic            last;
    } grid_row_t;

    logic [COLS-1:0] life_cells [ROWS];
    grid_row_t       expected_rows [$];
    int              mismatches = 0;

    // Every cell of the next generation comes from the old grid, both edges wrapped.
    task automatic advance_life_cells();
        logic [COLS-1:0] nxt [ROWS];
        int              rr;
        int              cc;
        int              n;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                n = 0;
                for (int dr = 0; dr < 3; dr++) begin
                    for (int dc = 0; dc < 3; dc++) begin
                        if (dr != 1 || dc != 1) begin
                            rr = (r + dr + ROWS - 1) % ROWS;
                            cc = (c + dc + COLS - 1) % COLS;
                            n += life_cells[rr][cc];
                        end
                    end
                end
                nxt[r][c] = (n == 3) || (life_cells[r][c] && n == 2);
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            life_cells[r] = nxt[r];
        end
    endtask

    task automatic queue_grid_rows();
        for (int r = 0; r < ROWS; r++) begin
            expected_rows.push_back('{row: RW'(r), cells: life_cells[r], last: (r == ROWS - 1)});
        end
    endtask

    always @(posedge aclk) begin : watch
        grid_row_t       want;
        lgs_mode_t       mode;
        logic [RW-1:0]   idx;
        logic [COLS-1:0] bits;
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                life_cells[r] = '0;
            end
            expected_rows.delete();
        end else begin
            // Compare first: an item accepted at this edge cannot produce a row yet.
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row: out_row_index %0d, out_row_bits %05h",
                           m_tdata[RW-1:0], m_tdata[RW+COLS-1:RW]);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    if (m_tdata[RW-1:0] !== want.row) begin
                        $error("out_row_index: expected %0d, got %0d",
                               want.row, m_tdata[RW-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[RW+COLS-1:RW] !== want.cells) begin
                        $error("out_row_bits: expected %05h, got %05h",
                               want.cells, m_tdata[RW+COLS-1:RW]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                mode = s_tdata[1:0];
                idx  = s_tdata[2+RW-1:2];
                bits = s_tdata[2+RW+COLS-1:2+RW];
                case (mode)
                    MODE_LOAD: begin
                        if (idx < ROWS) begin
                            life_cells[idx] = bits;
                        end
                    end
                    MODE_STEP: begin
                        advance_life_cells();
                        queue_grid_rows();
                    end
                    MODE_EMIT: begin
                        queue_grid_rows();
                    end
                    default: begin
                    end
                endcase
            end
        end
        rows_pending <= expected_rows.size();
        fail_count   <= mismatches;
    end

endmodule

FILE: test/tb_life_grid_generation_step_core.sv
`timescale 1ns / 1ps

module tb_life_grid_generation_step_core;
    import lgs_pkg::*;

    localparam int ROWS           = 7;
    localparam int COLS           = 20;
    localparam int RW             = $clog2(ROWS);
    localparam int SDW            = ((2 + RW + COLS + 7) / 8) * 8;
    localparam int MDW            = ((RW + COLS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 330;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 200;
    localparam int CYCLE_LIMIT    = 400000;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [SDW-1:0] s_tdata  = '0;   // mode, row_index, row_bits, zero fill
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [MDW-1:0] m_tdata;         // out_row_index, out_row_bits, zero fill
    logic           m_tlast;

    int   fail_count;
    int   rows_pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_go      = 1'b0;
    int   hold_left    = 0;
    int   cycles       = 0;
    int   counted      = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    life_grid_generation_step_core #(.ROWS(ROWS), .COLS(COLS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    life_grid_generation_step_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    // Receiver: random stalls, or a long hold-off once triggered.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            m_tready  <= 1'b0;
            hold_left <= HOLDOFF_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [COLS-1:0] row_pattern();
        case ($urandom_range(5))
            0: row_pattern = COLS'($urandom & $urandom);
            1: row_pattern = COLS'($urandom & $urandom & $urandom);
            2: row_pattern = COLS'($urandom | $urandom);
            3: row_pattern = COLS'(1) << $urandom_range(COLS - 1);
            4: row_pattern = {COLS{($urandom_range(1) == 1)}};
            default: row_pattern = COLS'($urandom);
        endcase
    endfunction

    // Hold valid high into the next item unless a gap is drawn.
    task automatic offer_item(input lgs_mode_t mode, input logic [RW-1:0] idx,
                              input logic [COLS-1:0] bits);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDW - 2 - RW - COLS){1'b0}}, bits, idx, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (mode == MODE_STEP || mode == MODE_EMIT || (mode == MODE_LOAD && idx < ROWS)) begin
            counted++;
        end
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain_rows();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
    endtask

    task automatic load_grid(input logic [ROWS-1:0] col0_rows, input int solid_row,
                             input logic [COLS-1:0] solid_bits);
        for (int r = 0; r < ROWS; r++) begin
            offer_item(MODE_LOAD, RW'(r),
                       (r == solid_row) ? solid_bits : {{(COLS - 1){1'b0}}, col0_rows[r]});
        end
    endtask

    initial begin : stimulus
        int phase;
        int pick;
        phase = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // cleared grid, extremes, dropped loads and ignored mode
        offer_item(MODE_EMIT, '0, '0);
        offer_item(MODE_LOAD, '0, '1);
        offer_item(MODE_LOAD, RW'(ROWS - 1), {1'b1, {(COLS - 2){1'b0}}, 1'b1});
        offer_item(MODE_LOAD, '1, '1);
        offer_item(MODE_IGNORE, '1, '1);
        offer_item(MODE_EMIT, '1, '1);
        offer_item(MODE_STEP, '0, '0);
        // vertical blinker on column 0 across the row wrap
        load_grid(ROWS'(1) | ROWS'(2) | (ROWS'(1) << (ROWS - 1)), -1, '0);
        offer_item(MODE_STEP, '0, '0);
        offer_item(MODE_STEP, '1, '1);
        // horizontal blinker on row 3 across the column wrap
        load_grid('0, 3, {1'b1, {(COLS - 3){1'b0}}, 2'b11});
        offer_item(MODE_STEP, '0, '0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted * 4 / RANDOM_ITEMS != phase) begin
                phase = counted * 4 / RANDOM_ITEMS;
                drain_rows();
                case (phase)
                    1: begin tx_idle_pct = 52; rx_stall_pct <= 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct <= 52; end
                    default: begin tx_idle_pct = 27; rx_stall_pct <= 27; end
                endcase
                if (phase == 1) begin
                    // stall the output long enough that the input backs up
                    hold_go <= 1'b1;
                    @(posedge aclk);
                    hold_go <= 1'b0;
                    repeat (4) offer_item(MODE_EMIT, RW'($urandom), row_pattern());
                end
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                repeat ($urandom_range(7, 1)) begin
                    offer_item(MODE_LOAD, RW'($urandom_range(ROWS - 1)), row_pattern());
                end
                repeat ($urandom_range(3, 1)) begin
                    offer_item(MODE_STEP, RW'($urandom), COLS'($urandom));
                end
                if ($urandom_range(1) == 1) begin
                    offer_item(MODE_EMIT, RW'($urandom), COLS'($urandom));
                end
            end else if (pick < 65) begin
                for (int r = 0; r < ROWS; r++) begin
                    offer_item(MODE_LOAD, RW'(r), row_pattern());
                end
                offer_item(MODE_STEP, RW'($urandom), COLS'($urandom));
            end else if (pick < 82) begin
                offer_item(($urandom_range(1) == 1) ? MODE_STEP : MODE_EMIT,
                           RW'($urandom), COLS'($urandom));
            end else if (pick < 91) begin
                offer_item(MODE_IGNORE, RW'($urandom), COLS'($urandom));
            end else begin
                offer_item(MODE_LOAD, RW'($urandom_range((1 << RW) - 1, ROWS)),
                           COLS'($urandom));
            end
        end

        drain_rows();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
